@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

  // Width of the match position reported with every result.
  localparam int MatchIdxW = 6;

  // Meaning of the command field of an input item.
  localparam logic CmdPattern = 1'b0;
  localparam logic CmdText    = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] char_value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_char;
    logic                 out_last;
    logic                 found;
    logic [MatchIdxW-1:0] match_index;
    logic                 empty_result;
    logic                 overflow;
  } out_item_t;

endpackage

@@ rtl/sfd_ram.sv @@
module sfd_ram #(
  parameter int Depth = 64,
  parameter int Width = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/substring_find_and_delete_top.sv @@
// Loading: one pattern or text byte is taken per cycle while the block is idle.
// Search: each byte comparison is a memory read, then a compare; start positions are
// tried left to right up to the first match or the last that fits, after a setup step.
// Output: each remaining text byte is fetched, loaded, then held until it is taken.
// Input is held off from the last text byte until the final result has been taken.
// Reset (asynchronous, active low) empties both runs and clears the overflow flag.
module substring_find_and_delete_top #(
  parameter int MAX_TEXT    = 64,
  parameter int MAX_PATTERN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfd_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfd_pkg::out_item_t out_item_o
);

  import sfd_pkg::*;

  // Address and count widths of the two stores. Counts must also hold the full depth.
  localparam int TAW = $clog2(MAX_TEXT);
  localparam int TCW = $clog2(MAX_TEXT + 1);
  localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PCW = $clog2(MAX_PATTERN + 1);
  // Width for sums of a text position and a pattern length.
  localparam int SW  = ((TCW > PCW) ? TCW : PCW) + 1;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StRead,
    StCompare,
    StEmit,
    StFetch,
    StLoad,
    StOut
  } state_e;

  state_e            state_q;
  logic [TCW-1:0]    tc_q;
  logic [PCW-1:0]    pc_q;
  logic              text_closed_q;
  logic              pat_closed_q;
  logic              dropped_q;
  logic [TCW-1:0]    pos_q;
  logic [PCW-1:0]    k_q;
  logic              hit_q;
  logic [TCW-1:0]    idx_q;
  logic [TCW-1:0]    rem_q;
  out_item_t         out_q;

  logic              in_acc;
  logic [TCW-1:0]    tc_base;
  logic [PCW-1:0]    pc_base;
  logic              t_room;
  logic              p_room;
  logic              t_we;
  logic              p_we;
  logic [7:0]        t_rdata;
  logic [7:0]        p_rdata;
  logic [TAW-1:0]    t_raddr;
  logic [PAW-1:0]    p_raddr;
  logic [SW-1:0]     pos_plus_k;
  logic [SW-1:0]     next_end;
  logic [PCW-1:0]    del;
  logic [SW-1:0]     skip_to;
  logic              skip;
  logic [TCW-1:0]    idx_eff;
  logic [TCW-1:0]    remain;

  // Input is only taken while no search or output run is in progress.
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // A byte that arrives while its run is closed starts a new run at index zero.
  assign tc_base = text_closed_q ? '0 : tc_q;
  assign pc_base = pat_closed_q ? '0 : pc_q;
  assign t_room  = (tc_base < TCW'(MAX_TEXT));
  assign p_room  = (pc_base < PCW'(MAX_PATTERN));
  assign t_we    = in_acc && (in_item_i.command == CmdText) && t_room;
  assign p_we    = in_acc && (in_item_i.command == CmdPattern) && p_room;

  // During the search the text is read at position plus offset and the pattern at
  // the offset. During output the text is read at the next surviving byte, which
  // jumps over the deleted occurrence.
  assign pos_plus_k = SW'(pos_q) + SW'(k_q);
  assign next_end   = SW'(pos_q) + SW'(1) + SW'(pc_q);
  assign del        = hit_q ? pc_q : '0;
  assign skip_to    = SW'(pos_q) + SW'(del);
  assign skip       = hit_q && (del != '0) && (idx_q == pos_q);
  assign idx_eff    = skip ? skip_to[TCW-1:0] : idx_q;
  assign remain     = TCW'(SW'(tc_q) - SW'(del));
  assign t_raddr    = (state_q == StFetch) ? idx_eff[TAW-1:0] : pos_plus_k[TAW-1:0];
  assign p_raddr    = k_q[PAW-1:0];

  sfd_ram #(
    .Depth(MAX_TEXT),
    .Width(8)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(tc_base[TAW-1:0]),
    .wdata_i(in_item_i.char_value),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  sfd_ram #(
    .Depth(MAX_PATTERN),
    .Width(8)
  ) u_pat_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(pc_base[PAW-1:0]),
    .wdata_i(in_item_i.char_value),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      tc_q          <= '0;
      pc_q          <= '0;
      text_closed_q <= 1'b1;
      pat_closed_q  <= 1'b1;
      dropped_q     <= 1'b0;
      pos_q         <= '0;
      k_q           <= '0;
      hit_q         <= 1'b0;
      idx_q         <= '0;
      rem_q         <= '0;
      out_q         <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (in_item_i.command == CmdPattern) begin
              // Bytes beyond capacity are dropped but still close the run.
              pc_q         <= p_room ? pc_base + PCW'(1) : pc_base;
              dropped_q    <= dropped_q || !p_room;
              pat_closed_q <= in_item_i.last;
            end else begin
              tc_q          <= t_room ? tc_base + TCW'(1) : tc_base;
              dropped_q     <= dropped_q || !t_room;
              text_closed_q <= in_item_i.last;
              if (in_item_i.last) begin
                state_q <= StStart;
              end
            end
          end
        end
        StStart: begin
          // An empty pattern matches at index zero; a pattern longer than the
          // text cannot match at all.
          pos_q <= '0;
          k_q   <= '0;
          if (SW'(pc_q) > SW'(tc_q)) begin
            hit_q   <= 1'b0;
            state_q <= StEmit;
          end else if (pc_q == '0) begin
            hit_q   <= 1'b1;
            state_q <= StEmit;
          end else begin
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StCompare;
        end
        StCompare: begin
          if (t_rdata == p_rdata) begin
            if (k_q + PCW'(1) == pc_q) begin
              hit_q   <= 1'b1;
              state_q <= StEmit;
            end else begin
              k_q     <= k_q + PCW'(1);
              state_q <= StRead;
            end
          end else begin
            k_q <= '0;
            if (next_end > SW'(tc_q)) begin
              hit_q   <= 1'b0;
              state_q <= StEmit;
            end else begin
              pos_q   <= pos_q + TCW'(1);
              state_q <= StRead;
            end
          end
        end
        StEmit: begin
          idx_q <= '0;
          rem_q <= remain;
          if (remain == '0) begin
            // Nothing survives the deletion: a single empty marker.
            out_q.out_char     <= '0;
            out_q.out_last     <= 1'b1;
            out_q.found        <= hit_q;
            out_q.match_index  <= hit_q ? MatchIdxW'(pos_q) : '0;
            out_q.empty_result <= 1'b1;
            out_q.overflow     <= dropped_q;
            state_q            <= StOut;
          end else begin
            state_q <= StFetch;
          end
        end
        StFetch: begin
          idx_q   <= idx_eff + TCW'(1);
          state_q <= StLoad;
        end
        StLoad: begin
          out_q.out_char     <= t_rdata;
          out_q.out_last     <= (rem_q == TCW'(1));
          out_q.found        <= hit_q;
          out_q.match_index  <= hit_q ? MatchIdxW'(pos_q) : '0;
          out_q.empty_result <= 1'b0;
          out_q.overflow     <= dropped_q;
          rem_q              <= rem_q - TCW'(1);
          state_q            <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            if (out_q.out_last) begin
              // The overflow flag lives until the run that reported it is out.
              dropped_q <= 1'b0;
              state_q   <= StIdle;
            end else begin
              state_q <= StFetch;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = (state_q == StOut);
  assign out_item_o  = out_q;

endmodule

@@ rtl/sfd_checker.sv @@
module sfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sfd_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sfd_pkg::out_item_t out_item_o
);

  // Input and output never overlap: the block loads or emits, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  // An empty marker is always the whole run and carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.empty_result |->
      out_item_o.out_last && (out_item_o.out_char == 8'd0))
    else $error("empty marker is malformed");

  // Without a match the reported position is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> (out_item_o.match_index == '0))
    else $error("match index set without a match");

  // Taking the final result of a run frees the input side again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.out_last |=> in_ready_o)
    else $error("block did not return to loading after a run");

  // A stalled result holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind substring_find_and_delete_top sfd_checker u_sfd_checker (.*);

@@ sim/substring_find_and_delete_checker.sv @@
module substring_find_and_delete_checker
  import sfd_pkg::*;
#(
  parameter int MaxText    = 64,
  parameter int MaxPattern = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatches_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  text_mem    [MaxText];
  logic [7:0]  pattern_mem [MaxPattern];
  int unsigned text_len;
  int unsigned pattern_len;
  bit          text_open;
  bit          pattern_open;
  bit          bytes_dropped;

  // Expected results, oldest first: surviving text bytes or a single empty marker.
  out_item_t   survivor_q [$];
  int          mismatch_count;
  int unsigned result_no;

  task automatic report(input string what);
    mismatch_count++;
    $display("[%0t] result %0d: %s", $time, result_no, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic push_survivor(input logic [7:0] ch, input bit final_one, input bit hit,
                               input int unsigned pos, input bit none_left);
    out_item_t r;
    r.out_char     = ch;
    r.out_last     = final_one;
    r.found        = hit;
    r.match_index  = MatchIdxW'(pos);
    r.empty_result = none_left;
    r.overflow     = bytes_dropped;
    survivor_q.push_back(r);
  endtask

  // First occurrence, left to right, over every start position that fits.
  task automatic predict_deletion();
    bit          hit;
    bit          same;
    int unsigned pos;
    int unsigned cut;
    int unsigned remain;
    int unsigned n;
    hit = 1'b0;
    pos = 0;
    cut = 0;
    for (int unsigned s = 0; !hit && s + pattern_len <= text_len; s++) begin
      same = 1'b1;
      for (int unsigned k = 0; k < pattern_len; k++) begin
        if (text_mem[s + k] != pattern_mem[k]) same = 1'b0;
      end
      if (same) begin
        hit = 1'b1;
        pos = s;
        cut = pattern_len;
      end
    end
    remain = text_len - cut;
    if (remain == 0) begin
      push_survivor(8'h00, 1'b1, hit, pos, 1'b1);
    end else begin
      n = 0;
      for (int unsigned i = 0; i < text_len; i++) begin
        if (!(hit && i >= pos && i < pos + cut)) begin
          n++;
          push_survivor(text_mem[i], n == remain, hit, pos, 1'b0);
        end
      end
    end
    bytes_dropped = 1'b0;
  endtask

  task automatic take_byte(input in_item_t item);
    if (item.command == CmdPattern) begin
      if (!pattern_open) begin
        pattern_len  = 0;
        pattern_open = 1'b1;
      end
      if (pattern_len < MaxPattern) begin
        pattern_mem[pattern_len] = item.char_value;
        pattern_len++;
      end else begin
        bytes_dropped = 1'b1;
      end
      if (item.last) pattern_open = 1'b0;
    end else begin
      if (!text_open) begin
        text_len  = 0;
        text_open = 1'b1;
      end
      if (text_len < MaxText) begin
        text_mem[text_len] = item.char_value;
        text_len++;
      end else begin
        bytes_dropped = 1'b1;
      end
      if (item.last) begin
        text_open = 1'b0;
        predict_deletion();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      text_len       = 0;
      pattern_len    = 0;
      text_open      = 1'b0;
      pattern_open   = 1'b0;
      bytes_dropped  = 1'b0;
      mismatch_count = 0;
      result_no      = 0;
      survivor_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (survivor_q.size() == 0) begin
          report($sformatf("arrived with nothing expected: %p", out_item_i));
        end else begin
          want = survivor_q.pop_front();
          check_field("out_char", out_item_i.out_char, want.out_char);
          check_field("out_last", 8'(out_item_i.out_last), 8'(want.out_last));
          check_field("found", 8'(out_item_i.found), 8'(want.found));
          check_field("match_index", 8'(out_item_i.match_index), 8'(want.match_index));
          check_field("empty_result", 8'(out_item_i.empty_result), 8'(want.empty_result));
          check_field("overflow", 8'(out_item_i.overflow), 8'(want.overflow));
        end
        result_no++;
      end
      if (in_valid_i && in_ready_i) begin
        take_byte(in_item_i);
      end
      mismatches_o <= mismatch_count;
      pending_o    <= survivor_q.size();
    end
  end

endmodule

@@ sim/substring_find_and_delete_top_test.sv @@
module substring_find_and_delete_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int MaxText     = 64;
  localparam int MaxPattern  = 32;
  localparam int ResetCycles = 11;
  localparam int RandomItems = 250;
  // Idling changes pattern after this many input items, in three phases.
  localparam int PhaseItems  = 90;
  // The slowest search tries 33 start positions against a full 32-byte pattern, each
  // comparison a memory read and then a compare. The watchdog allows several times
  // that with no item moving on either channel.
  localparam int QuietLimit  = 20000;
  // After the last expected result, keep waiting for stray results.
  localparam int DrainCycles = 300;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int          mismatches;
  int          pending;
  int          recv_idle_pct = 61;
  int unsigned items_sent;
  // The most recent pattern bytes sent, kept so that text runs can carry them.
  logic [7:0]  pattern_bytes [$];

  logic moved;
  assign moved = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i);

  substring_find_and_delete_top #(
    .MAX_TEXT   (MaxText),
    .MAX_PATTERN(MaxPattern)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  substring_find_and_delete_checker #(
    .MaxText   (MaxText),
    .MaxPattern(MaxPattern)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The receiver stalls at random with the rate that the current phase sets.
  initial out_ready_i = 1'b0;
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Sends one item. The sender may first idle for a random number of cycles; then valid
  // rises and stays up with the payload held until the block takes the item. Valid is
  // lowered only inside the idle loop and after the last item, so back-to-back items keep it high.
  task automatic send_byte(input logic cmd, input logic [7:0] ch, input logic last);
    in_item_t item;
    int       send_idle_pct;
    item.command    = cmd;
    item.char_value = ch;
    item.last       = last;
    // First the sender idles lightly and the receiver heavily, then the reverse, then
    // neither idles at all.
    if (items_sent < PhaseItems) begin
      send_idle_pct = 17;
      recv_idle_pct <= 61;
    end else if (items_sent < 2 * PhaseItems) begin
      send_idle_pct = 61;
      recv_idle_pct <= 17;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Most bytes come from a tiny alphabet around a random base so that patterns occur in
  // the text by chance as well; now and then a job uses fully random bytes.
  function automatic logic [7:0] pick_char(input logic [7:0] base, input bit wide);
    return wide ? 8'($urandom) : base ^ 8'($urandom_range(3, 0));
  endfunction

  // One job: an optional pattern run, then a text run that often carries the pattern
  // somewhere inside it, so that the search and the deletion get real work. A few jobs
  // go past capacity, leave a run open, or are plain noise.
  task automatic send_job(input int unsigned job_no);
    int unsigned plen;
    int unsigned tlen;
    int unsigned at;
    int unsigned roll;
    logic [7:0]  base;
    logic [7:0]  c;
    bit          wide;
    bit          close_run;
    logic [7:0]  text_bytes [$];
    base = 8'($urandom);
    wide = ($urandom_range(9, 0) == 0);

    // Noise: a handful of items with every field random.
    if ($urandom_range(99, 0) < 8) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(1'($urandom_range(1, 0)), 8'($urandom), 1'($urandom_range(1, 0)));
      end
      return;
    end

    // Pattern run. A zero length keeps the pattern from the job before. Job 3 runs the
    // pattern past capacity and job 8 the text, unless it is noise, so that the overflow path is reached early.
    roll = $urandom_range(99, 0);
    if (job_no == 3 || roll < 3) plen = $urandom_range(MaxPattern + 4, MaxPattern + 1);
    else if (roll < 20) plen = 0;
    else plen = $urandom_range(4, 1);
    if (plen != 0) begin
      pattern_bytes.delete();
      // Now and then the pattern stays open, so the text search uses what is stored
      // so far and later pattern bytes append to it.
      close_run = ($urandom_range(9, 0) != 0);
      for (int unsigned i = 0; i < plen; i++) begin
        c = pick_char(base, wide);
        if (i < MaxPattern) pattern_bytes.push_back(c);
        send_byte(CmdPattern, c, close_run && i == plen - 1);
      end
    end

    // Text run.
    roll = $urandom_range(99, 0);
    if (job_no == 8 || roll < 3) tlen = $urandom_range(MaxText + 4, MaxText + 1);
    else if (roll < 13 && pattern_bytes.size() != 0) tlen = pattern_bytes.size();
    else tlen = $urandom_range(12, 1);
    for (int unsigned i = 0; i < tlen; i++) text_bytes.push_back(pick_char(base, wide));
    if (pattern_bytes.size() != 0 && pattern_bytes.size() <= tlen &&
        $urandom_range(9, 0) < 6) begin
      at = $urandom_range(tlen - pattern_bytes.size(), 0);
      foreach (pattern_bytes[k]) text_bytes[at + k] = pattern_bytes[k];
    end
    // A text run left open is continued by the next job's text bytes.
    close_run = ($urandom_range(19, 0) != 0);
    foreach (text_bytes[i]) begin
      send_byte(CmdText, text_bytes[i], close_run && i == tlen - 1);
    end
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned job_no;
    int unsigned random_start;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    items_sent = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right after reset no pattern was loaded: the empty pattern is found at index 0
    // and the text comes back whole.
    send_byte(CmdText, 8'h41, 1'b1);
    // Pattern equal to the whole text: nothing remains, so a single empty marker.
    send_byte(CmdPattern, 8'h41, 1'b1);
    send_byte(CmdText, 8'h41, 1'b1);
    // The match ends on the final text byte, with the byte extremes as content.
    send_byte(CmdPattern, 8'h00, 1'b0);
    send_byte(CmdPattern, 8'hFF, 1'b1);
    send_byte(CmdText, 8'hFF, 1'b0);
    send_byte(CmdText, 8'h00, 1'b0);
    send_byte(CmdText, 8'hFF, 1'b1);
    // Pattern longer than the text: not found, text unchanged.
    send_byte(CmdPattern, 8'h80, 1'b0);
    send_byte(CmdPattern, 8'h7F, 1'b0);
    send_byte(CmdPattern, 8'h01, 1'b1);
    send_byte(CmdText, 8'h80, 1'b0);
    send_byte(CmdText, 8'h7F, 1'b1);
    // The text closes while the pattern is still open; the next pattern byte appends.
    send_byte(CmdPattern, 8'h5A, 1'b0);
    send_byte(CmdText, 8'h5A, 1'b0);
    send_byte(CmdText, 8'h11, 1'b1);
    send_byte(CmdPattern, 8'h11, 1'b1);
    send_byte(CmdText, 8'hA5, 1'b0);
    send_byte(CmdText, 8'h5A, 1'b0);
    send_byte(CmdText, 8'h11, 1'b1);
    // Plain miss.
    send_byte(CmdPattern, 8'hC3, 1'b1);
    send_byte(CmdText, 8'h3C, 1'b1);

    random_start = items_sent;
    job_no = 0;
    while (items_sent < random_start + RandomItems) begin
      send_job(job_no);
      job_no++;
    end
    // Close any text run that the random part left open.
    send_byte(CmdText, 8'($urandom), 1'b1);
    in_valid_i <= 1'b0;

    // The checker's count is registered and reflects the last item only after the next edge.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Ends the run when nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (moved) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no item moved for %0d cycles", $time, QuietLimit);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/substring_find_and_delete_top.sv
rtl/sfd_checker.sv
sim/substring_find_and_delete_checker.sv
sim/substring_find_and_delete_top_test.sv
